// File: design/page_translate_allocate_top_macros.svh
// ----------------------------------------------------------------------------
// Page translate/allocate assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_TRANSLATE_ALLOCATE_TOP_MACROS_SVH
`define PAGE_TRANSLATE_ALLOCATE_TOP_MACROS_SVH

// same-cycle implication
`define PTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pta_pkg.sv
// ----------------------------------------------------------------------------
// Page translate/allocate package
// Shared widths, status codes, register map and result type.
// ----------------------------------------------------------------------------
package pta_pkg;

  localparam int ADDR_W           = 32;
  localparam int STATUS_W         = 2;
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;
  localparam int DEF_ENTRIES      = 64;
  localparam int DEF_PAGE_BITS    = 13;

  // register word index (paddr bit 2 and up)
  localparam logic REG_TRANSLATE_ENABLE = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_PASS = 2'd0,
    ST_HIT  = 2'd1,
    ST_NEW  = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] phys;
    status_e           status;
  } pta_res_t;

endpackage

// File: design/pta_tag_ram.sv
// ----------------------------------------------------------------------------
// Page tag memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pta_tag_ram #(
  parameter int ENTRIES = 64,
  parameter int TAG_W   = 19,
  parameter int IDX_W   = 6
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [TAG_W-1:0] wr_data_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output logic [TAG_W-1:0] rd_data_o
);

  logic [TAG_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// File: design/pta_seq.sv
// ----------------------------------------------------------------------------
// Page translate/allocate sequencer (passthrough when translation is off)
// Walks the used prefix of the tag table through one shared comparator,
// then hits, allocates the next free entry, or reports a full table.
// ----------------------------------------------------------------------------
module pta_seq #(
  parameter int ENTRIES   = 64,
  parameter int PAGE_BITS = 13
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      enable_i,
  input  logic [pta_pkg::ADDR_W-1:0] addr_i,
  output logic                      busy_o,
  output logic                      done_o,
  input  logic                      take_i,
  output pta_pkg::pta_res_t         res_o
);
  import pta_pkg::*;

  localparam int TAG_W = ADDR_W - PAGE_BITS;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [CNT_W-1:0]     issue_q, issue_d;
  logic [CNT_W-1:0]     fill_q, fill_d;
  logic                 pend_q, pend_d;
  logic [IDX_W-1:0]     pend_idx_q, pend_idx_d;
  logic [TAG_W-1:0]     page_q, page_d;
  logic [PAGE_BITS-1:0] offset_q, offset_d;
  pta_res_t             res_q, res_d;

  logic                 wr_en;
  logic [TAG_W-1:0]     rd_tag;
  logic                 more;
  logic                 match;
  logic                 has_free;

  pta_tag_ram #(
    .ENTRIES (ENTRIES),
    .TAG_W   (TAG_W),
    .IDX_W   (IDX_W)
  ) u_tag_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (fill_q[IDX_W-1:0]),
    .wr_data_i (page_q),
    .rd_addr_i (issue_q[IDX_W-1:0]),
    .rd_data_o (rd_tag)
  );

  // entries below fill_q are used; entries are never freed, so the used
  // set is always a prefix of the table
  assign more     = (issue_q < fill_q);
  assign match    = pend_q && (rd_tag == page_q);
  assign has_free = (fill_q < CNT_W'(ENTRIES));

  always_comb begin
    state_d    = state_q;
    issue_d    = issue_q;
    fill_d     = fill_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    page_d     = page_q;
    offset_d   = offset_q;
    res_d      = res_q;
    wr_en      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          page_d   = addr_i[ADDR_W-1:PAGE_BITS];
          offset_d = addr_i[PAGE_BITS-1:0];
          issue_d  = '0;
          if (enable_i) begin
            state_d = S_SCAN;
          end else begin
            res_d.phys   = addr_i;
            res_d.status = ST_PASS;
            state_d      = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          res_d.phys   = ADDR_W'({pend_idx_q, offset_q});
          res_d.status = ST_HIT;
          state_d      = S_DONE;
        end else if (!more) begin
          // last pending compare missed, or the table is empty
          if (has_free) begin
            wr_en        = 1'b1;
            fill_d       = fill_q + CNT_W'(1);
            res_d.phys   = ADDR_W'({fill_q[IDX_W-1:0], offset_q});
            res_d.status = ST_NEW;
          end else begin
            res_d.phys   = '0;
            res_d.status = ST_FULL;
          end
          state_d = S_DONE;
        end else begin
          pend_d     = 1'b1;
          pend_idx_d = issue_q[IDX_W-1:0];
          issue_d    = issue_q + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q    <= issue_d;
    pend_idx_q <= pend_idx_d;
    page_q     <= page_d;
    offset_q   <= offset_d;
    res_q      <= res_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign res_o  = res_q;

endmodule

// File: design/page_translate_allocate_top.sv
// ----------------------------------------------------------------------------
// Page translate/allocate top level
// Logical to physical address translation with on-demand page allocation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one logical_address_i per
//   transaction. Output channel: out_valid_o / out_stall_i carry
//   physical_address_o and status_o (pass, hit, new, full) per transaction.
//   translate_enable sits at APB byte address 0; write it only while idle.
// Operation:
//   One item at a time. Passthrough skips the table walk.
//   With translation on, the tag table is walked one entry per cycle through
//   a single comparator and a read-registered tag memory, over the N used
//   entries (at most ENTRIES), until a hit or the end of the used prefix.
//   in_stall_o stays high from accept until the result has moved into the
//   output register.
// Reset:
//   Table empty (fill count cleared), translation disabled, no output valid.
//   No clearing pass is needed: only the used prefix is ever read.
// Stall:
//   A held result sits in the output register; a new transaction may be
//   accepted and worked on meanwhile, and waits for the register to free up.
// ----------------------------------------------------------------------------
`include "page_translate_allocate_top_macros.svh"

module page_translate_allocate_top #(
  parameter int ENTRIES   = pta_pkg::DEF_ENTRIES,
  parameter int PAGE_BITS = pta_pkg::DEF_PAGE_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pta_pkg::ADDR_W-1:0]  logical_address_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pta_pkg::ADDR_W-1:0]  physical_address_o,
  output logic [pta_pkg::STATUS_W-1:0] status_o,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pta_pkg::PADDR_W-1:0] paddr,
  input  logic [pta_pkg::PDATA_W-1:0] pwdata,
  output logic [pta_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import pta_pkg::*;

  logic                te_q;
  logic                reg_sel;
  logic                in_accept;
  logic                seq_busy;
  logic                seq_done;
  logic                res_take;
  pta_res_t            seq_res;
  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_phys_q;
  logic [STATUS_W-1:0] out_status_q;

  // ---- configuration: one register, word index from paddr bit 2 ----
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_TRANSLATE_ENABLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      te_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      te_q <= pwdata[0];
    end
  end

  assign prdata = reg_sel ? PDATA_W'(te_q) : '0;

  // ---- input side ----
  assign in_stall_o = seq_busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  pta_seq #(
    .ENTRIES   (ENTRIES),
    .PAGE_BITS (PAGE_BITS)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_accept),
    .enable_i (te_q),
    .addr_i   (logical_address_i),
    .busy_o   (seq_busy),
    .done_o   (seq_done),
    .take_i   (res_take),
    .res_o    (seq_res)
  );

  // ---- output register: loads when empty or being drained ----
  assign res_take = seq_done && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_phys_q   <= seq_res.phys;
      out_status_q <= seq_res.status;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = out_phys_q;
  assign status_o           = out_status_q;

  // ---- checks ----
  `PTA_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall_o, "not busy after accept")
  `PTA_ASSERT_NOW(a_full_zero, out_valid_o && (status_o == ST_FULL),
                  physical_address_o == '0, "full result with nonzero address")
  `PTA_ASSERT_NOW(a_table_needs_enable,
                  out_valid_o && (status_o == ST_HIT || status_o == ST_NEW),
                  te_q, "table result while translation disabled")
  `PTA_ASSERT_NEXT(a_take_frees_seq, res_take, !seq_busy, "sequencer held after handoff")

endmodule

// File: tb/tb_page_translate_allocate_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page translate/allocate testbench
// Drives logical addresses through the block. A local model of the page table
// predicts each physical address and status, and the results are checked in
// order. A directed table covers passthrough, page zero on free entries, page
// extremes, register bit masking and ignored register indexes. Random
// segments then fill the table to its full state under several settings of
// translate_enable and several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_page_translate_allocate_top;
  import pta_pkg::*;

  localparam int ENTRIES        = DEF_ENTRIES;
  localparam int PAGE_BITS      = DEF_PAGE_BITS;
  localparam int TAG_W          = ADDR_W - PAGE_BITS;
  localparam int NUM_SEGMENTS   = 6;
  localparam int ITEMS_PER_SEG  = 210;
  localparam int DRAIN_CYCLES   = 100;
  localparam int LIMIT_CYCLES   = 1_000_000;
  localparam int MAX_PRINTED    = 40;

  // byte addresses on the APB port: register 0 and an unmapped word
  localparam logic [PADDR_W-1:0] ADDR_ENABLE   = {REG_TRANSLATE_ENABLE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_RESERVED = {~REG_TRANSLATE_ENABLE, 2'b00};

  // translate_enable setting per random segment, bit 0 first
  localparam logic [NUM_SEGMENTS-1:0] ENABLE_PLAN = 6'b101101;

  localparam logic [TAG_W-1:0]     PAGE_TOP    = '1;
  localparam logic [PAGE_BITS-1:0] OFFSET_TOP  = '1;

  // --------------------------------------------------------------------------
  // Clock, reset, DUT signals
  // --------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ADDR_W-1:0]   logical_address_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ADDR_W-1:0]   physical_address_o;
  logic [STATUS_W-1:0] status_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  page_translate_allocate_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .logical_address_i  (logical_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .physical_address_o (physical_address_o),
    .status_o           (status_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // --------------------------------------------------------------------------
  // Page table model and expected translations
  // --------------------------------------------------------------------------
  logic [TAG_W-1:0] tag_table [ENTRIES];
  logic             tag_used  [ENTRIES];
  logic             xlate_en;

  pta_res_t         expected_translations [$];
  logic [TAG_W-1:0] mapped_pages [$];   // pages known to hold an entry
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               send_idle_pct;
  int               recv_stall_pct;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tag_table[i] = '0;
      tag_used[i]  = 1'b0;
    end
    xlate_en = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] phys_of(input int idx,
                                                input logic [PAGE_BITS-1:0] off);
    logic [63:0] wide;
    // an index past 32 bits after the shift is truncated
    wide = (64'(idx) << PAGE_BITS) | 64'(off);
    return wide[ADDR_W-1:0];
  endfunction

  // Translates one address and updates the table the way the block must.
  function automatic pta_res_t predict_translation(input logic [ADDR_W-1:0] la);
    logic [TAG_W-1:0]     pg;
    logic [PAGE_BITS-1:0] off;
    int                   hit_idx;
    int                   free_idx;
    pta_res_t             res;
    pg       = la[ADDR_W-1:PAGE_BITS];
    off      = la[PAGE_BITS-1:0];
    hit_idx  = -1;
    free_idx = -1;
    if (!xlate_en) begin
      res.phys   = la;
      res.status = ST_PASS;
      return res;
    end
    // free entries never match, even with an equal tag
    for (int i = 0; i < ENTRIES; i++) begin
      if (tag_used[i] && tag_table[i] == pg && hit_idx < 0) hit_idx = i;
      if (!tag_used[i] && free_idx < 0) free_idx = i;
    end
    if (hit_idx >= 0) begin
      res.phys   = phys_of(hit_idx, off);
      res.status = ST_HIT;
    end else if (free_idx >= 0) begin
      tag_table[free_idx] = pg;
      tag_used[free_idx]  = 1'b1;
      res.phys   = phys_of(free_idx, off);
      res.status = ST_NEW;
    end else begin
      // table full: state untouched
      res.phys   = '0;
      res.status = ST_FULL;
    end
    return res;
  endfunction

  // Mostly pages already mapped, some page extremes, the rest fresh pages.
  function automatic logic [ADDR_W-1:0] pick_address();
    int                   roll;
    logic [31:0]          raw;
    logic [TAG_W-1:0]     pg;
    logic [PAGE_BITS-1:0] off;
    roll = $urandom_range(99);
    raw  = $urandom();
    if (mapped_pages.size() > 0 && roll < 65) begin
      pg = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
    end else if (roll < 70) begin
      pg = raw[0] ? PAGE_TOP : '0;
    end else begin
      pg = raw[TAG_W-1:0];
    end
    roll = $urandom_range(9);
    raw  = $urandom();
    if (roll == 0)      off = '0;
    else if (roll == 1) off = OFFSET_TOP;
    else                off = raw[PAGE_BITS-1:0];
    return {pg, off};
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Input side: one transaction per call, random idle cycles before it.
  // Inputs change at the falling edge; acceptance is seen at the rising edge.
  // A typed expectation replaces the predicted one, but the model still runs
  // so that its table follows the block.
  // --------------------------------------------------------------------------
  task automatic drive_item(input logic [ADDR_W-1:0] la, input bit typed,
                            input pta_res_t typed_res);
    pta_res_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    logical_address_i = la;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = predict_translation(la);
    if (res.status == ST_NEW) mapped_pages.push_back(la[ADDR_W-1:PAGE_BITS]);
    expected_translations.push_back(typed ? typed_res : res);
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_translations.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr,
                           input logic [PDATA_W-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    // only register 0 exists, and only its bit 0 is kept
    if (addr[PADDR_W-1:2] == REG_TRANSLATE_ENABLE) xlate_en = data[0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr,
                          input logic [PDATA_W-1:0] want);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want)
      report_mismatch($sformatf("read of 0x%0h: got 0x%08h, want 0x%08h",
                                addr, prdata, want));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall, in-order check of every accepted transaction
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    pta_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_translations.size() == 0) begin
        report_mismatch($sformatf("unexpected result phys 0x%08h status %0d",
                                  physical_address_o, status_o));
      end else begin
        want = expected_translations.pop_front();
        if (physical_address_o !== want.phys)
          report_mismatch($sformatf("physical_address 0x%08h, want 0x%08h",
                                    physical_address_o, want.phys));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
      end
    end
  end

  // hard stop if the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed table. For reads, data holds the expected register value.
  // --------------------------------------------------------------------------
  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_WRITE,
    ROW_READ
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [PADDR_W-1:0] addr;
    logic [ADDR_W-1:0]  data;
    logic               typed;
    logic [ADDR_W-1:0]  exp_phys;
    status_e            exp_status;
  } dir_row_t;

  localparam int N_DIR = 19;

  dir_row_t dir_rows [N_DIR] = '{
    // translation off after reset: addresses pass through, extremes first
    '{ROW_ITEM,  ADDR_ENABLE,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_PASS},
    '{ROW_ITEM,  ADDR_ENABLE,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ST_PASS},
    '{ROW_READ,  ADDR_ENABLE,   32'h0000_0000, 1'b0, 32'h0,         ST_PASS},
    // bit 0 clear with all upper bits set: stays off
    '{ROW_WRITE, ADDR_ENABLE,   32'hFFFF_FFFE, 1'b0, 32'h0,         ST_PASS},
    '{ROW_READ,  ADDR_ENABLE,   32'h0000_0000, 1'b0, 32'h0,         ST_PASS},
    '{ROW_ITEM,  ADDR_ENABLE,   32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5, ST_PASS},
    '{ROW_WRITE, ADDR_ENABLE,   32'hFFFF_FFFF, 1'b0, 32'h0,         ST_PASS},
    '{ROW_READ,  ADDR_ENABLE,   32'h0000_0001, 1'b0, 32'h0,         ST_PASS},
    // page zero against free entries with zero tags: must allocate, not hit
    '{ROW_ITEM,  ADDR_ENABLE,   32'h0000_1FFF, 1'b1, 32'h0000_1FFF, ST_NEW},
    '{ROW_ITEM,  ADDR_ENABLE,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_HIT},
    // top page lands in entry 1
    '{ROW_ITEM,  ADDR_ENABLE,   32'hFFFF_FFFF, 1'b1, 32'h0000_3FFF, ST_NEW},
    '{ROW_ITEM,  ADDR_ENABLE,   32'hFFFF_E000, 1'b1, 32'h0000_2000, ST_HIT},
    // write to an unmapped word leaves translation on
    '{ROW_WRITE, ADDR_RESERVED, 32'h0000_0000, 1'b0, 32'h0,         ST_PASS},
    '{ROW_ITEM,  ADDR_ENABLE,   32'h1234_5678, 1'b0, 32'h0,         ST_PASS},
    '{ROW_WRITE, ADDR_ENABLE,   32'h0000_0000, 1'b0, 32'h0,         ST_PASS},
    '{ROW_ITEM,  ADDR_ENABLE,   32'h1234_5678, 1'b1, 32'h1234_5678, ST_PASS},
    // table kept while translation was off
    '{ROW_WRITE, ADDR_ENABLE,   32'h0000_0001, 1'b0, 32'h0,         ST_PASS},
    '{ROW_ITEM,  ADDR_ENABLE,   32'h1234_5678, 1'b0, 32'h0,         ST_PASS},
    '{ROW_ITEM,  ADDR_ENABLE,   32'h0000_0001, 1'b0, 32'h0,         ST_PASS}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [PDATA_W-1:0] wdata;
    pta_res_t           typed_res;
    in_valid_i        = 1'b0;
    logical_address_i = '0;
    out_stall_i       = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    rst_ni            = 1'b0;
    send_idle_pct     = 14;
    recv_stall_pct    = 86;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part; registers are only touched once the block is idle
    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        ROW_ITEM: begin
          typed_res.phys   = dir_rows[r].exp_phys;
          typed_res.status = dir_rows[r].exp_status;
          drive_item(dir_rows[r].data, dir_rows[r].typed, typed_res);
        end
        ROW_WRITE: begin
          wait_drain();
          apb_write(dir_rows[r].addr, dir_rows[r].data);
        end
        default: begin
          wait_drain();
          apb_read(dir_rows[r].addr, dir_rows[r].data);
        end
      endcase
    end

    // random segments: receiver-heavy stalling, then sender-heavy idling, then none
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct  = 14;
          recv_stall_pct = 86;
        end
        1: begin
          send_idle_pct  = 86;
          recv_stall_pct = 14;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      wait_drain();
      wdata    = $urandom();
      wdata[0] = ENABLE_PLAN[seg];
      apb_write(ADDR_ENABLE, wdata);
      apb_read(ADDR_ENABLE, {{(PDATA_W-1){1'b0}}, xlate_en});
      repeat (ITEMS_PER_SEG) drive_item(pick_address(), 1'b0, '0);
    end

    wait_drain();
    // catch stray results after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
